@@ design/uart8n1_pkg.sv @@
// ----------------------------------------------------------------------------
// UART 8N1 receiver package
// Shared types and constants for the receiver core and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package uart8n1_pkg;

    localparam int DATA_BITS_DEF         = 8;
    localparam int RECOVER_HALF_BITS_DEF = 20;

    localparam int BIT_TICKS_W   = 16;
    localparam int TICK_COUNT_W  = 17;
    localparam int BIT_INDEX_W   = 4;
    localparam int RECOVER_W     = 5;
    localparam int BYTE_W        = 8;

    localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RESET = 16'd104;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_DATA    = 2'd1,
        PH_STOP    = 2'd2,
        PH_RECOVER = 2'd3
    } rx_phase_t;

    typedef struct packed {
        logic              frame_dropped;
        logic [BYTE_W-1:0] rx_byte;
        logic              byte_valid;
    } rx_result_t;

endpackage

`default_nettype wire

@@ design/uart_8n1_receiver.sv @@
// ----------------------------------------------------------------------------
// UART 8N1 receiver
// Oversampled asynchronous serial receiver, one line sample per beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one receive-line sample per beat in s_tdata[0] (1 = mark).
//   m_ channel: exactly one result beat per sample beat, in order.
//     m_tdata holds the received byte (zero unless byte_valid is set),
//     m_tuser[0] is byte_valid, m_tuser[1] is frame_dropped.
//   cfg_we/cfg_wdata write bit_ticks, the number of samples per bit; write
//   it only while the line is idle and no results are outstanding.
// Path: a sample beat is first held in the sample register, and its result
// is loaded into the result register when the result side can advance.
// Throughput: one sample per cycle unless m_tready stalls the output; the frame
// step is a single pass of counter and shift logic between the two registers.
// Reset: bit_ticks returns to 104, the frame tracker goes idle and both
// stages are emptied.
// Stall: with m_tready low the result and sample registers fill and then
// s_tready drops; no sample or result is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_8n1_receiver #(
    parameter int DATA_BITS         = uart8n1_pkg::DATA_BITS_DEF,
    parameter int RECOVER_HALF_BITS = uart8n1_pkg::RECOVER_HALF_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [uart8n1_pkg::BIT_TICKS_W-1:0] cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,  // [0] rx_line, [7:1] zero
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [uart8n1_pkg::BYTE_W-1:0]           m_tdata,  // [7:0] rx_byte
    output logic [1:0]                               m_tuser   // byte_valid, frame_dropped
);

    logic [uart8n1_pkg::BIT_TICKS_W-1:0] bit_ticks_reg;
    logic                                m_valid_reg;
    uart8n1_pkg::rx_result_t             result_reg;
    uart8n1_pkg::rx_result_t             step_result;
    logic                                advance;
    logic                                line_valid;
    logic                                line;
    logic                                step_en;

    assign advance = !m_valid_reg || m_tready;
    assign step_en = advance && line_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_ticks_reg <= uart8n1_pkg::BIT_TICKS_RESET;
        end else if (cfg_we) begin
            bit_ticks_reg <= cfg_wdata;
        end
    end

    uart8n1_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_line     (s_tdata[0]),
        .advance    (advance),
        .line_valid (line_valid),
        .line       (line)
    );

    uart8n1_core #(
        .DATA_BITS         (DATA_BITS),
        .RECOVER_HALF_BITS (RECOVER_HALF_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .line      (line),
        .bit_ticks (bit_ticks_reg),
        .result    (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= line_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            result_reg <= step_result;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = result_reg.rx_byte;
    assign m_tuser[0] = result_reg.byte_valid;
    assign m_tuser[1] = result_reg.frame_dropped;

    a_flags_exclusive : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("byte_valid and frame_dropped both set");

    a_byte_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("rx_byte nonzero without byte_valid");

    a_step_to_out : assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> m_valid_reg)
        else $error("stepped sample produced no result");

    a_full_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        (line_valid && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("sample accepted while both stages are held");

endmodule

`default_nettype wire

@@ design/uart8n1_core.sv @@
// ----------------------------------------------------------------------------
// UART 8N1 receiver core
// Frame state and one-sample step: start detect, data sampling, stop check
// and line recovery after a framing error.
// ----------------------------------------------------------------------------
`default_nettype none

module uart8n1_core #(
    parameter int DATA_BITS         = uart8n1_pkg::DATA_BITS_DEF,
    parameter int RECOVER_HALF_BITS = uart8n1_pkg::RECOVER_HALF_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                step_en,
    input  wire logic                                line,
    input  wire logic [uart8n1_pkg::BIT_TICKS_W-1:0] bit_ticks,
    output uart8n1_pkg::rx_result_t                  result
);

    localparam int TW = uart8n1_pkg::TICK_COUNT_W;
    localparam int IW = uart8n1_pkg::BIT_INDEX_W;
    localparam int RW = uart8n1_pkg::RECOVER_W;
    localparam int BW = uart8n1_pkg::BYTE_W;

    localparam logic [IW-1:0] DataBitsN   = IW'(DATA_BITS);
    localparam logic [RW-1:0] RecoverHalf = RW'(RECOVER_HALF_BITS);

    uart8n1_pkg::rx_phase_t phase_reg, phase_next;
    logic [TW-1:0]          tick_reg, tick_next;
    logic [IW-1:0]          index_reg, index_next;
    logic [BW-1:0]          shift_reg, shift_next;
    logic [RW-1:0]          recover_reg, recover_next;

    logic [TW-1:0] tick_dec;
    logic [TW-1:0] full_wait;
    logic [TW-1:0] half_wait;
    logic [TW-1:0] first_wait;
    logic [TW-1:0] first_sum;

    always_comb begin
        first_sum  = {1'b0, bit_ticks} + {2'b00, bit_ticks[uart8n1_pkg::BIT_TICKS_W-1:1]};
        first_wait = (first_sum == '0) ? TW'(1) : first_sum;
        full_wait  = (bit_ticks == '0) ? TW'(1) : {1'b0, bit_ticks};
        half_wait  = (bit_ticks[uart8n1_pkg::BIT_TICKS_W-1:1] == '0) ? TW'(1)
                   : {2'b00, bit_ticks[uart8n1_pkg::BIT_TICKS_W-1:1]};
        tick_dec   = tick_reg - TW'(1);
    end

    always_comb begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        index_next    = index_reg;
        shift_next    = shift_reg;
        recover_next  = recover_reg;
        result        = '0;
        case (phase_reg)
            uart8n1_pkg::PH_IDLE: begin
                if (!line) begin
                    phase_next = uart8n1_pkg::PH_DATA;
                    tick_next  = first_wait;
                    index_next = '0;
                    shift_next = '0;
                end
            end
            uart8n1_pkg::PH_DATA: begin
                tick_next = tick_dec;
                if (tick_dec == '0) begin
                    if (line && (index_reg < IW'(BW))) begin
                        shift_next[index_reg[2:0]] = 1'b1;
                    end
                    index_next = index_reg + IW'(1);
                    tick_next  = full_wait;
                    if (index_next >= DataBitsN) begin
                        phase_next = uart8n1_pkg::PH_STOP;
                    end
                end
            end
            uart8n1_pkg::PH_STOP: begin
                tick_next = tick_dec;
                if (tick_dec == '0) begin
                    if (line) begin
                        result.byte_valid = 1'b1;
                        result.rx_byte    = shift_reg;
                        phase_next        = uart8n1_pkg::PH_IDLE;
                    end else begin
                        result.frame_dropped = 1'b1;
                        phase_next           = uart8n1_pkg::PH_RECOVER;
                        recover_next         = RW'(1);
                        tick_next            = half_wait;
                    end
                end
            end
            default: begin
                tick_next = tick_dec;
                if (tick_dec == '0) begin
                    if ((recover_reg >= RecoverHalf) || line) begin
                        phase_next   = uart8n1_pkg::PH_IDLE;
                        recover_next = '0;
                    end else begin
                        recover_next = recover_reg + RW'(1);
                        tick_next    = half_wait;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= uart8n1_pkg::PH_IDLE;
            tick_reg    <= '0;
            index_reg   <= '0;
            shift_reg   <= '0;
            recover_reg <= '0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            index_reg   <= index_next;
            shift_reg   <= shift_next;
            recover_reg <= recover_next;
        end
    end

endmodule

`default_nettype wire

@@ design/uart8_n1_receiver_placeholder.sv @@
// ----------------------------------------------------------------------------
// UART 8N1 receiver sample register
// Input beat register with ready backpressure from the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module uart8n1_in_stage (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire logic s_line,
    input  wire logic advance,
    output logic      line_valid,
    output logic      line
);

    logic valid_reg;
    logic line_reg;

    assign s_tready   = !valid_reg || advance;
    assign line_valid = valid_reg;
    assign line       = line_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            line_reg <= s_line;
        end
    end

endmodule

`default_nettype wire
